// ----- hw/rtl/sljx_pkg.sv -----
// Shared types and constants for the sync/length/XOR frame receiver.
// Depends on nothing; used by sync_length_xor_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

package sljx_pkg;

  // Byte and field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  // Output word: index, value, id, status, padded to whole bytes
  localparam int unsigned OutFieldsW = 3 * ByteW + StatusW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Framing constants
  localparam logic [ByteW-1:0] SyncByte = 8'hA5;
  localparam logic [ByteW-1:0] CmdInfer = 8'h01;

  // Frame status codes, in order of precedence after ok
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CMD  = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_CSUM = 2'd3
  } status_e;

  // Result kinds carried on tuser
  typedef enum logic {
    KIND_FEATURE = 1'b0,
    KIND_FRAME   = 1'b1
  } kind_e;

endpackage

`default_nettype wire

// ----- hw/rtl/sync_length_xor_frame_receiver.sv -----
// Sync / length / XOR-checksum frame receiver: parses received bytes into
// feature words and one end-of-frame status word. Depends on sljx_pkg.
// A byte accepted into the input register is parsed from there; its result word,
// if it makes one, is then registered in the output register.
// Throughput: one byte per cycle; a held byte leaves the input register only
// when the output register is free, so a stalled output stops intake.
// Reset (rst_ni low, asynchronous): parser returns to sync hunting, all
// stored frame state clears, and no word is valid on either stage.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_xor_frame_receiver #(
  parameter int unsigned FEATURE_COUNT = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Received bytes
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [sljx_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  // Result words
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [7:0] feature_index, [15:8] feature_value, [23:16] frame_id,
  // [25:24] frame_status, [31:26] zero
  output logic [sljx_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [0:0]                          m_axis_tuser   // [0] item_kind
);

  localparam int unsigned BW = sljx_pkg::ByteW;
  localparam logic [BW-1:0] FeatCnt = BW'(FEATURE_COUNT);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CSUM    = 3'd5
  } phase_e;

  // Input register
  logic          in_vld_q;
  logic [BW-1:0] in_byte_q;

  // Parser state
  phase_e                phase_q, phase_d;
  logic [BW-1:0]         cmd_q, cmd_d;
  logic [BW-1:0]         tag_q, tag_d;
  logic [BW-1:0]         len_q, len_d;
  logic [BW-1:0]         cnt_q, cnt_d;
  logic [BW-1:0]         csum_q, csum_d;
  sljx_pkg::status_e     err_q, err_d;

  // Output register
  logic                                 out_vld_q;
  logic [BW-1:0]                        out_idx_q, out_val_q, out_id_q;
  sljx_pkg::status_e                    out_st_q;
  sljx_pkg::kind_e                      out_kind_q;

  // Result of the current word
  logic                 emit;
  sljx_pkg::kind_e      res_kind;
  logic [BW-1:0]        res_idx, res_val;
  sljx_pkg::status_e    res_st;

  logic out_free, process;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign process       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Parser next state and result
  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    tag_d    = tag_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    csum_d   = csum_q;
    err_d    = err_q;
    emit     = 1'b0;
    res_kind = sljx_pkg::KIND_FEATURE;
    res_idx  = '0;
    res_val  = '0;
    res_st   = sljx_pkg::ST_OK;
    case (phase_q)
      PH_CMD: begin
        cmd_d   = in_byte_q;
        csum_d  = in_byte_q;
        phase_d = PH_ID;
      end
      PH_ID: begin
        tag_d   = in_byte_q;
        csum_d  = csum_q ^ in_byte_q;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d  = in_byte_q;
        cnt_d  = '0;
        csum_d = csum_q ^ in_byte_q;
        if (cmd_q != sljx_pkg::CmdInfer) begin
          err_d = sljx_pkg::ST_BAD_CMD;
        end else if (in_byte_q != FeatCnt) begin
          err_d = sljx_pkg::ST_BAD_LEN;
        end else begin
          err_d = sljx_pkg::ST_OK;
        end
        phase_d = (in_byte_q == '0) ? PH_CSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // features go out only for frames without a header error
        emit    = (err_q == sljx_pkg::ST_OK);
        res_idx = cnt_q;
        res_val = in_byte_q;
        csum_d  = csum_q ^ in_byte_q;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_d == len_q) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        emit     = 1'b1;
        res_kind = sljx_pkg::KIND_FRAME;
        res_st   = err_q;
        if (err_q == sljx_pkg::ST_OK && in_byte_q != csum_q) begin
          res_st = sljx_pkg::ST_BAD_CSUM;
        end
        phase_d = PH_HUNT;
      end
      default: begin
        // hunting, and unused codes behave the same
        phase_d = (in_byte_q == sljx_pkg::SyncByte) ? PH_CMD : PH_HUNT;
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      csum_q  <= '0;
      err_q   <= sljx_pkg::ST_OK;
    end else if (process) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      csum_q  <= csum_d;
      err_q   <= err_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (process && emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      out_kind_q <= res_kind;
      out_idx_q  <= res_idx;
      out_val_q  <= res_val;
      out_id_q   <= tag_q;
      out_st_q   <= res_st;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = sljx_pkg::OutDataW'({out_st_q, out_id_q, out_val_q, out_idx_q});

  // Checks on the parser
  a_frame_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_kind_q == sljx_pkg::KIND_FRAME |->
      out_idx_q == '0 && out_val_q == '0)
    else $error("frame word carries feature fields");

  a_feature_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_kind_q == sljx_pkg::KIND_FEATURE |->
      out_st_q == sljx_pkg::ST_OK)
    else $error("feature word carries a status");

  a_no_feature_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && phase_q == PH_PAYLOAD && err_q != sljx_pkg::ST_OK |=>
      !m_axis_tvalid)
    else $error("feature emitted in a bad frame");

  a_csum_gives_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && phase_q == PH_CSUM |=>
      m_axis_tvalid && out_kind_q == sljx_pkg::KIND_FRAME)
    else $error("checksum byte gave no frame word");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> cnt_q < len_q)
    else $error("payload count ran past length");

endmodule

`default_nettype wire

// ----- tb/tb_sync_length_xor_frame_receiver.sv -----
// Self-checking testbench for sync_length_xor_frame_receiver: a scoreboard
// class tracks frame parsing and checks every result word in order.
// Depends on sljx_pkg and the receiver RTL.
`timescale 1ns / 1ps

module tb_sync_length_xor_frame_receiver;

  localparam int unsigned FeatureCount = 16;
  localparam int unsigned ByteTarget   = 1100;
  localparam int unsigned LongHold     = 300;

  // Parser phases tracked by the scoreboard
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CSUM    = 3'd5
  } parse_phase_e;

  // One expected result word
  typedef struct packed {
    sljx_pkg::kind_e            kind;
    logic [sljx_pkg::ByteW-1:0] index;
    logic [sljx_pkg::ByteW-1:0] value;
    logic [sljx_pkg::ByteW-1:0] id;
    sljx_pkg::status_e          status;
  } rx_word_t;

  // Tracks the frame parser and holds the words it should emit
  class frame_tracker;
    parse_phase_e               phase    = PH_HUNT;
    logic [sljx_pkg::ByteW-1:0] command  = '0;
    logic [sljx_pkg::ByteW-1:0] tag      = '0;
    logic [sljx_pkg::ByteW-1:0] length   = '0;
    logic [sljx_pkg::ByteW-1:0] count    = '0;
    logic [sljx_pkg::ByteW-1:0] checksum = '0;
    sljx_pkg::status_e          err      = sljx_pkg::ST_OK;
    rx_word_t                   pending_words[$];
    int                         errors      = 0;
    int                         n_features  = 0;
    int                         n_status[4] = '{0, 0, 0, 0};

    // Advance the parser by one accepted byte
    function void take_byte(logic [sljx_pkg::ByteW-1:0] b);
      rx_word_t          w;
      sljx_pkg::status_e st;
      case (phase)
        PH_CMD: begin
          command  = b;
          checksum = b;
          phase    = PH_ID;
        end
        PH_ID: begin
          tag      = b;
          checksum ^= b;
          phase    = PH_LEN;
        end
        PH_LEN: begin
          length   = b;
          count    = '0;
          checksum ^= b;
          // bad command outranks bad length
          if (command != sljx_pkg::CmdInfer) err = sljx_pkg::ST_BAD_CMD;
          else if (b != sljx_pkg::ByteW'(FeatureCount)) err = sljx_pkg::ST_BAD_LEN;
          else err = sljx_pkg::ST_OK;
          phase = (b == '0) ? PH_CSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          // payload of a bad frame is consumed silently
          if (err == sljx_pkg::ST_OK) begin
            w = '{sljx_pkg::KIND_FEATURE, count, b, tag, sljx_pkg::ST_OK};
            pending_words.push_back(w);
          end
          checksum ^= b;
          count++;
          if (count == length) phase = PH_CSUM;
        end
        PH_CSUM: begin
          st = err;
          if (st == sljx_pkg::ST_OK && b != checksum) st = sljx_pkg::ST_BAD_CSUM;
          w = '{sljx_pkg::KIND_FRAME, '0, '0, tag, st};
          pending_words.push_back(w);
          phase = PH_HUNT;
        end
        default: phase = (b == sljx_pkg::SyncByte) ? PH_CMD : PH_HUNT;
      endcase
    endfunction

    function void cmp_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t ERROR %s mismatch: expected 0x%0h, got 0x%0h", $time, name, e, a);
        errors++;
      end
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_word(logic [0:0] kind, logic [sljx_pkg::OutDataW-1:0] data);
      rx_word_t w;
      if (pending_words.size() == 0) begin
        $display("%0t ERROR unexpected word: expected none, got kind %0d data 0x%0h",
                 $time, kind, data);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      cmp_field("item_kind", w.kind, kind);
      cmp_field("feature_index", w.index, data[7:0]);
      cmp_field("feature_value", w.value, data[15:8]);
      cmp_field("frame_id", w.id, data[23:16]);
      cmp_field("frame_status", w.status, data[25:24]);
      cmp_field("padding", 0, data[sljx_pkg::OutDataW-1:26]);
      if (w.kind == sljx_pkg::KIND_FEATURE) n_features++;
      else n_status[w.status]++;
    endfunction

    function int left();
      return pending_words.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n    = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic [sljx_pkg::ByteW-1:0]    s_tdata  = '0;
  logic                          m_tready = 1'b0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [sljx_pkg::OutDataW-1:0] m_tdata;
  logic [0:0]                    m_tuser;

  frame_tracker tracker = new;
  int send_idle  = 0;
  int recv_stall = 0;
  int hold_left  = 0;
  bit hold_req   = 1'b0;
  int bytes_sent = 0;

  sync_length_xor_frame_receiver #(
    .FEATURE_COUNT(FeatureCount)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitors: sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready) tracker.take_byte(s_tdata);
      if (m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Byte with extra weight on the extremes and the sync value
  function automatic logic [sljx_pkg::ByteW-1:0] rand_byte();
    logic [sljx_pkg::ByteW-1:0] r;
    case ($urandom_range(9))
      0: r = 8'h00;
      1: r = 8'hFF;
      2: r = sljx_pkg::SyncByte;
      default: r = sljx_pkg::ByteW'($urandom_range(255));
    endcase
    return r;
  endfunction

  // Offer one byte; returns at the falling edge after it was taken
  task automatic send_byte(input logic [sljx_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Full frame with random payload; optionally a corrupted checksum
  task automatic send_frame(input logic [sljx_pkg::ByteW-1:0] cmd,
                            input logic [sljx_pkg::ByteW-1:0] id,
                            input logic [sljx_pkg::ByteW-1:0] len, input bit bad_csum);
    logic [sljx_pkg::ByteW-1:0] cs;
    logic [sljx_pkg::ByteW-1:0] d;
    send_byte(sljx_pkg::SyncByte);
    send_byte(cmd);
    send_byte(id);
    send_byte(len);
    cs = cmd ^ id ^ len;
    for (int i = 0; i < int'(len); i++) begin
      d = rand_byte();
      cs ^= d;
      send_byte(d);
    end
    if (bad_csum) cs ^= 8'h01 << $urandom_range(7);
    send_byte(cs);
  endtask

  task automatic wait_drained();
    while (tracker.left() != 0) @(negedge clk);
  endtask

  // Main stimulus
  initial begin
    int                         phase_no;
    int                         prev_phase;
    int                         pick;
    logic [sljx_pkg::ByteW-1:0] cmd;
    logic [sljx_pkg::ByteW-1:0] len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ignored bytes while hunting, zero length, error precedence
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA4);
    send_frame(8'h00, 8'h00, 8'h00, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'h03, 1'b0);
    send_frame(sljx_pkg::CmdInfer, 8'h5A, 8'h00, 1'b0);
    send_frame(sljx_pkg::CmdInfer, 8'h80, 8'h01, 1'b1);

    // Random: mostly well-formed frames, some broken ones and noise
    prev_phase = -1;
    while (bytes_sent < ByteTarget) begin
      phase_no = (bytes_sent * 4) / ByteTarget;
      if (phase_no != prev_phase) begin
        case (phase_no)
          0: begin send_idle = 0;  recv_stall = 0;  end
          1: begin send_idle = 69; recv_stall = 0;  end
          2: begin
            // pause until everything is out, then hold the receiver off
            s_tvalid <= 1'b0;
            wait_drained();
            send_idle  = 0;
            recv_stall = 69;
            hold_req   = 1'b1;
          end
          default: begin send_idle = 24; recv_stall = 24; end
        endcase
        prev_phase = phase_no;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(sljx_pkg::CmdInfer, rand_byte(), sljx_pkg::ByteW'(FeatureCount),
                   $urandom_range(9) == 0);
      end else if (pick < 65) begin
        cmd = rand_byte();
        if (cmd == sljx_pkg::CmdInfer) cmd = 8'h00;
        len = ($urandom_range(39) == 0) ? 8'hFF :
              sljx_pkg::ByteW'($urandom_range(FeatureCount + 4));
        send_frame(cmd, rand_byte(), len, 1'($urandom_range(1)));
      end else if (pick < 75) begin
        len = sljx_pkg::ByteW'($urandom_range(20));
        if (len == sljx_pkg::ByteW'(FeatureCount)) len = 8'h00;
        send_frame(sljx_pkg::CmdInfer, rand_byte(), len, 1'($urandom_range(1)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(rand_byte());
      end else begin
        // truncated frame: sync and a few random bytes
        send_byte(sljx_pkg::SyncByte);
        repeat ($urandom_range(1, 8)) send_byte(rand_byte());
      end
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d bytes and %0d feature words", bytes_sent,
             tracker.n_features);
    $display("Frame status counts ok/bad cmd/bad len/bad checksum: %0d/%0d/%0d/%0d",
             tracker.n_status[sljx_pkg::ST_OK], tracker.n_status[sljx_pkg::ST_BAD_CMD],
             tracker.n_status[sljx_pkg::ST_BAD_LEN], tracker.n_status[sljx_pkg::ST_BAD_CSUM]);
    if (tracker.errors == 0 && tracker.left() == 0) begin
      $display("sync_length_xor_frame_receiver verification clean");
    end else begin
      $display("sync_length_xor_frame_receiver verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d words outstanding", tracker.left());
    $display("sync_length_xor_frame_receiver verification failed");
    $finish;
  end

endmodule
